### hw/rtl/kpm_pkg.sv
// kpm_pkg: shared types and codes for the keyword prefix matcher
// command, status and fsm codes, token passed along the cell chain
// no dependencies
`timescale 1ns / 1ps

package kpm_pkg;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_MATCH = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	// status codes carried in m_tuser
	localparam logic [1:0] STAT_MATCHED = 2'd0;
	localparam logic [1:0] STAT_NOMATCH = 2'd1;
	localparam logic [1:0] STAT_END     = 2'd2;

	// field widths of the stream words
	localparam int unsigned ENTRY_W = 5;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned KIDX_W  = 5;

	// scan phase of the token
	typedef enum logic [1:0] {
		PH_SKIP,
		PH_EQUAL,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic   valid;
		phase_t phase;
		logic   found;
		logic   low_zero;
	} tok_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LAUNCH,
		S_SCAN,
		S_DECIDE
	} state_t;

	// case fold with nul mapped to 1
	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (r == 8'd0) begin
			r = 8'd1;
		end
		if (r >= 8'h41 && r <= 8'h5a) begin
			r = r + 8'd32;
		end
		return r;
	endfunction

endpackage

### hw/rtl/kpm_cell.sv
// kpm_cell: one table entry of the keyword prefix matcher
// holds the entry bytes and refines the scan token passing through it
// depends on kpm_pkg
`timescale 1ns / 1ps

module kpm_cell #(
	parameter int unsigned MAX_KEYWORDS = 32,
	parameter int unsigned KEY_BYTES    = 16,
	parameter int unsigned CELL_IDX     = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [$clog2(KEY_BYTES)-1:0]           wr_addr,
	input  logic [7:0]                             wr_data,
	input  logic [$clog2(KEY_BYTES+1)-1:0]         depth,
	input  logic [7:0]                             ch,
	input  logic [$clog2(MAX_KEYWORDS+1)-1:0]      lo,
	input  logic [$clog2(MAX_KEYWORDS+1)-1:0]      hi,
	input  kpm_pkg::tok_t                          tok_in,
	input  logic [$clog2(MAX_KEYWORDS+1)-1:0]      nlo_in,
	input  logic [$clog2(MAX_KEYWORDS+1)-1:0]      nhi_in,
	output kpm_pkg::tok_t                          tok_out,
	output logic [$clog2(MAX_KEYWORDS+1)-1:0]      nlo_out,
	output logic [$clog2(MAX_KEYWORDS+1)-1:0]      nhi_out
);

	localparam int unsigned AW = $clog2(KEY_BYTES);
	localparam int unsigned DW = $clog2(KEY_BYTES + 1);
	localparam int unsigned IW = $clog2(MAX_KEYWORDS + 1);
	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

	logic [7:0]    store_q [KEY_BYTES];
	logic [7:0]    byte_q;
	kpm_pkg::tok_t tok_q;
	logic [IW-1:0] nlo_q;
	logic [IW-1:0] nhi_q;
	logic          in_range;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	// bytes past the end of an entry read as nul
	always_ff @(posedge clk) begin
		if (depth >= DW'(KEY_BYTES)) begin
			byte_q <= 8'd0;
		end else begin
			byte_q <= store_q[depth[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		nlo_q <= nlo_in;
		nhi_q <= nhi_in;
	end

	assign in_range = (MY_IDX >= lo) && (MY_IDX < hi);

	always_comb begin
		tok_out = tok_q;
		nlo_out = nlo_q;
		nhi_out = nhi_q;
		if (tok_q.valid && in_range) begin
			if (MY_IDX == lo) begin
				tok_out.low_zero = (byte_q == 8'd0);
			end
			case (tok_q.phase)
				kpm_pkg::PH_SKIP: begin
					if (byte_q == ch) begin
						tok_out.phase = kpm_pkg::PH_EQUAL;
						tok_out.found = 1'b1;
						nlo_out       = MY_IDX;
					end else if (byte_q > ch) begin
						tok_out.phase = kpm_pkg::PH_DONE;
					end
				end
				kpm_pkg::PH_EQUAL: begin
					if (byte_q != ch) begin
						tok_out.phase = kpm_pkg::PH_DONE;
						nhi_out       = MY_IDX;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hw/rtl/keyword_prefix_matcher.sv
// keyword_prefix_matcher: top level, control sequencer and chain of entry cells
// depends on kpm_pkg and kpm_cell
`timescale 1ns / 1ps

// Matches a character stream against a sorted table of lower-case, nul-terminated
// keywords. Load words (tuser 0) write one table byte, end words (tuser 2) close a
// running match, and each match character (tuser 1) runs in order: the word is
// taken, a scan token is launched, the token walks the row of entry cells (one cell
// per cycle, every cell reading its byte at the current depth), and the new
// candidate range is settled or the result given once the output register is free.
// A character that no longer extends any candidate yields one result word with
// the folded delimiter; keyword_count is sampled when a match begins. The table
// has no reset and must be loaded before use. A finished word sits in an output
// register; new words are held off while it waits, and the next one can be taken
// in the cycle that it leaves.
module keyword_prefix_matcher #(
	parameter int unsigned MAX_KEYWORDS = 32,
	parameter int unsigned KEY_BYTES    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: keyword_count
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // entry[4:0], position[8:5], char_byte[16:9], zero pad
	input  logic [1:0]  s_tuser,   // command[1:0]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // keyword_index[4:0], delimiter[12:5], zero pad
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int unsigned AW = $clog2(KEY_BYTES);
	localparam int unsigned DW = $clog2(KEY_BYTES + 1);
	localparam int unsigned IW = $clog2(MAX_KEYWORDS + 1);

	// input word fields
	logic [kpm_pkg::ENTRY_W-1:0] in_entry;
	logic [kpm_pkg::POS_W-1:0]   in_pos;
	logic [7:0]                  in_char;
	logic [7:0]                  in_fold;
	logic                        accept;

	assign in_entry = s_tdata[4:0];
	assign in_pos   = s_tdata[8:5];
	assign in_char  = s_tdata[16:9];
	assign in_fold  = kpm_pkg::fold_char(in_char);
	assign accept   = s_tvalid && s_tready;

	// control state
	kpm_pkg::state_t           state_q, state_nxt;
	logic                      matching_q;
	logic [5:0]                count_q;
	logic [IW-1:0]             lo_q;
	logic [IW-1:0]             hi_q;
	logic [DW-1:0]             depth_q;
	logic [7:0]                ch_q;

	// token as it leaves the last cell
	kpm_pkg::tok_t             fin_tok_q;
	logic [IW-1:0]             fin_nlo_q;
	logic [IW-1:0]             fin_nhi_q;

	// output register
	logic                      out_valid_q;
	logic [1:0]                out_stat_q;
	logic [kpm_pkg::KIDX_W-1:0] out_kidx_q;
	logic [7:0]                out_delim_q;

	// fsm strobes
	logic                      out_free;
	logic                      launch;
	logic                      decide;

	// range a new match character works on
	logic [IW-1:0]             lo_eff;
	logic [IW-1:0]             hi_eff;
	logic [DW-1:0]             depth_eff;
	logic [IW-1:0]             hi_start;
	logic                      range_empty;

	// cell chain
	kpm_pkg::tok_t             tok_w [MAX_KEYWORDS+1];
	logic [IW-1:0]             nlo_w [MAX_KEYWORDS+1];
	logic [IW-1:0]             nhi_w [MAX_KEYWORDS+1];
	logic                      load_we;
	logic [AW-1:0]             load_addr;

	assign out_free = !out_valid_q || m_tready;

	// keyword_count above the table size acts as the table size
	assign hi_start = (32'(count_q) > 32'(MAX_KEYWORDS)) ? IW'(MAX_KEYWORDS) : IW'(count_q);

	always_comb begin
		if (matching_q) begin
			lo_eff    = lo_q;
			hi_eff    = hi_q;
			depth_eff = depth_q;
		end else begin
			lo_eff    = '0;
			hi_eff    = hi_start;
			depth_eff = '0;
		end
	end

	assign range_empty = (lo_eff >= hi_eff);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			kpm_pkg::S_IDLE: begin
				if (accept && s_tuser == kpm_pkg::CMD_MATCH && !range_empty) begin
					state_nxt = kpm_pkg::S_LAUNCH;
				end
			end
			kpm_pkg::S_LAUNCH: begin
				state_nxt = kpm_pkg::S_SCAN;
			end
			kpm_pkg::S_SCAN: begin
				if (tok_w[MAX_KEYWORDS].valid) begin
					state_nxt = kpm_pkg::S_DECIDE;
				end
			end
			kpm_pkg::S_DECIDE: begin
				if (out_free) begin
					state_nxt = kpm_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = kpm_pkg::S_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready = 1'b0;
		launch   = 1'b0;
		decide   = 1'b0;
		unique case (state_q)
			kpm_pkg::S_IDLE: begin
				s_tready = out_free;
			end
			kpm_pkg::S_LAUNCH: begin
				launch = 1'b1;
			end
			kpm_pkg::S_SCAN: begin
			end
			kpm_pkg::S_DECIDE: begin
				decide = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpm_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// match state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matching_q  <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				case (s_tuser)
					kpm_pkg::CMD_END: begin
						if (matching_q) begin
							matching_q  <= 1'b0;
							out_valid_q <= 1'b1;
						end
					end
					kpm_pkg::CMD_MATCH: begin
						lo_q    <= lo_eff;
						hi_q    <= hi_eff;
						depth_q <= depth_eff;
						if (range_empty) begin
							matching_q  <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							matching_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (decide) begin
				if (fin_tok_q.found) begin
					// narrow the range; a run of equal bytes up to the end keeps hi
					lo_q    <= fin_nlo_q;
					if (fin_tok_q.phase != kpm_pkg::PH_EQUAL) begin
						hi_q <= fin_nhi_q;
					end
					depth_q <= depth_q + DW'(1);
				end else begin
					matching_q  <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// result payload, written in every cycle that can set the valid bit
	always_ff @(posedge clk) begin
		if (accept && s_tuser == kpm_pkg::CMD_MATCH) begin
			ch_q <= in_fold;
		end
		if (accept && s_tuser == kpm_pkg::CMD_END) begin
			out_stat_q  <= kpm_pkg::STAT_END;
			out_kidx_q  <= '0;
			out_delim_q <= 8'd0;
		end else if (accept && s_tuser == kpm_pkg::CMD_MATCH) begin
			out_stat_q  <= kpm_pkg::STAT_NOMATCH;
			out_kidx_q  <= '0;
			out_delim_q <= in_fold;
		end else if (decide) begin
			// entry at the bottom of the range ends exactly at this depth
			if (fin_tok_q.low_zero) begin
				out_stat_q <= kpm_pkg::STAT_MATCHED;
				out_kidx_q <= kpm_pkg::KIDX_W'(lo_q);
			end else begin
				out_stat_q <= kpm_pkg::STAT_NOMATCH;
				out_kidx_q <= '0;
			end
			out_delim_q <= ch_q;
		end
	end

	// token leaving the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_tok_q <= '0;
		end else if (state_q == kpm_pkg::S_SCAN) begin
			fin_tok_q <= tok_w[MAX_KEYWORDS];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == kpm_pkg::S_SCAN) begin
			fin_nlo_q <= nlo_w[MAX_KEYWORDS];
			fin_nhi_q <= nhi_w[MAX_KEYWORDS];
		end
	end

	// fresh token enters cell 0 in the launch cycle
	always_comb begin
		tok_w[0]          = '0;
		tok_w[0].valid    = launch;
		tok_w[0].phase    = kpm_pkg::PH_SKIP;
		nlo_w[0]          = '0;
		nhi_w[0]          = '0;
	end

	// table loads beyond the entry length are dropped
	assign load_we   = accept && (s_tuser == kpm_pkg::CMD_LOAD) &&
	                   (32'(in_pos) < 32'(KEY_BYTES));
	assign load_addr = AW'(in_pos);

	for (genvar g = 0; g < MAX_KEYWORDS; g++) begin : g_cell
		logic cell_we;

		assign cell_we = load_we && (32'(in_entry) == 32'(g));

		kpm_cell #(
			.MAX_KEYWORDS (MAX_KEYWORDS),
			.KEY_BYTES    (KEY_BYTES),
			.CELL_IDX     (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (cell_we),
			.wr_addr (load_addr),
			.wr_data (in_char),
			.depth   (depth_q),
			.ch      (ch_q),
			.lo      (lo_q),
			.hi      (hi_q),
			.tok_in  (tok_w[g]),
			.nlo_in  (nlo_w[g]),
			.nhi_in  (nhi_w[g]),
			.tok_out (tok_w[g+1]),
			.nlo_out (nlo_w[g+1]),
			.nhi_out (nhi_w[g+1])
		);
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {3'b000, out_delim_q, out_kidx_q};

endmodule

### hw/rtl/kpm_checker.sv
// kpm_checker: port-level checks for the keyword prefix matcher
// bound to keyword_prefix_matcher; depends on kpm_pkg
`timescale 1ns / 1ps

module kpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// end of stream carries neither index nor delimiter
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == kpm_pkg::STAT_END |-> m_tdata == 16'd0)
		else $error("end word with non-zero payload");

	// index only on a keyword match
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != kpm_pkg::STAT_MATCHED |-> m_tdata[4:0] == 5'd0)
		else $error("index set without a match");

	// a table load never produces a word
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == kpm_pkg::CMD_LOAD && !m_tvalid |=> !m_tvalid)
		else $error("word appeared after a table load");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

endmodule

bind keyword_prefix_matcher kpm_checker u_kpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
